// ===== hw/rtl/bfsp_pkg.sv =====
// Shared types and constants of the bit field stream packer.
`default_nettype none

package bfsp_pkg;

   // Fixed field widths of one item
   localparam int VALUE_W = 32;
   localparam int BITS_W  = 6;

   // A field at a non-zero bit offset spans one byte more than its value
   localparam int SPAN_W    = VALUE_W + 8;
   localparam int ACC_BYTES = SPAN_W / 8;

   // Stream port widths, tdata padded to whole bytes
   localparam int REQ_TDATA_W = ((VALUE_W + BITS_W + 7) / 8) * 8;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = VALUE_W;
   localparam int RSP_TUSER_W = 2;

   // Operation codes carried in req_tuser
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [VALUE_W-1:0] field_value;
      logic [BITS_W-1:0]  field_bits;
   } bfsp_item_type;

   typedef struct packed {
      logic [VALUE_W-1:0] read_value;
      logic               underrun;
      logic               overflow;
   } bfsp_res_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bfsp_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
`default_nettype none

module bfsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bfsp_engine.sv =====
// Byte sequencer: position tracking and read-modify-write over the byte store.
`default_nettype none

module bfsp_engine #(
   parameter int STORE_BYTES    = 4096,
   parameter int MAX_FIELD_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  bfsp_pkg::bfsp_item_type item,
   output logic                    idle,
   output logic                    res_valid,
   input  logic                    res_ready,
   output bfsp_pkg::bfsp_res_type  res
);

   import bfsp_pkg::*;

   localparam int AW        = $clog2(STORE_BYTES);
   localparam int CW        = $clog2(STORE_BYTES + 1);
   localparam int EW        = CW + 4;
   localparam int NW        = $clog2(MAX_FIELD_BITS + 1);
   localparam int CSW       = NW + 1;
   localparam int MAX_SPAN  = (MAX_FIELD_BITS + 14) / 8;
   localparam int BCW       = $clog2(MAX_SPAN + 1);
   localparam int KW        = $clog2(ACC_BYTES + 1);

   localparam logic [EW-1:0] LIMIT_BITS = EW'(STORE_BYTES * 8);
   localparam logic [CW-1:0] STORE_END  = CW'(STORE_BYTES);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic              mode_ff, mode_in;
   logic [2:0]        bit_ff, bit_in;
   logic [NW-1:0]     n_ff, n_in;
   logic [CW-1:0]     addr_ff, addr_in;
   logic [BCW-1:0]    left_ff, left_in;
   logic [SPAN_W-1:0] wdata_ff, wdata_in;
   logic [SPAN_W-1:0] acc_ff, acc_in;
   logic [KW-1:0]     k_ff, k_in;
   logic              und_ff, und_in;
   logic              ovf_ff, ovf_in;
   logic [CW-1:0]     written_ff, written_in;
   logic [CW-1:0]     wbyte_ff, wbyte_in;
   logic [2:0]        wbit_ff, wbit_in;
   logic [CW-1:0]     rbyte_ff, rbyte_in;
   logic [2:0]        rbit_ff, rbit_in;
   logic              p1_valid_ff, p1_valid_in;
   logic [AW-1:0]     p1_addr_ff, p1_addr_in;
   logic [7:0]        p1_data_ff, p1_data_in;
   logic              p1_merge_ff, p1_merge_in;

   logic              rd_en, wr_en;
   logic [AW-1:0]     rd_addr;
   logic [7:0]        rd_data, wr_data;

   logic [NW-1:0]      n_c;
   logic [VALUE_W-1:0] mask_c, mask_r;
   logic [EW-1:0]      wend, wend_sat, rend;
   logic               w_ovf, r_und;
   logic [CSW-1:0]     wsum, rsum;
   logic [CSW-4:0]     wcnt, rcnt;
   logic [SPAN_W-1:0]  shifted, aligned;
   logic               need_old;

   // Accept-time arithmetic: clamp width, end positions, bytes touched
   always_comb begin
      if (item.field_bits == '0) begin
         n_c = NW'(1);
      end else if (int'(item.field_bits) > MAX_FIELD_BITS) begin
         n_c = NW'(MAX_FIELD_BITS);
      end else begin
         n_c = NW'(item.field_bits);
      end
      mask_c   = ~({VALUE_W{1'b1}} << n_c);
      wend     = {1'b0, wbyte_ff, wbit_ff} + EW'(n_c);
      w_ovf    = wend > LIMIT_BITS;
      wend_sat = w_ovf ? LIMIT_BITS : wend;
      rend     = {1'b0, rbyte_ff, rbit_ff} + EW'(n_c);
      r_und    = rend > {1'b0, written_ff, 3'b000};
      wsum     = CSW'(wbit_ff) + CSW'(n_c) + CSW'(7);
      rsum     = CSW'(rbit_ff) + CSW'(n_c) + CSW'(7);
      wcnt     = wsum[CSW-1:3];
      rcnt     = rsum[CSW-1:3];
      shifted  = SPAN_W'(item.field_value & mask_c) << wbit_ff;
   end

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      bit_in      = bit_ff;
      n_in        = n_ff;
      addr_in     = addr_ff;
      left_in     = left_ff;
      wdata_in    = wdata_ff;
      acc_in      = acc_ff;
      k_in        = k_ff;
      und_in      = und_ff;
      ovf_in      = ovf_ff;
      written_in  = written_ff;
      wbyte_in    = wbyte_ff;
      wbit_in     = wbit_ff;
      rbyte_in    = rbyte_ff;
      rbit_in     = rbit_ff;
      p1_valid_in = 1'b0;
      p1_addr_in  = p1_addr_ff;
      p1_data_in  = p1_data_ff;
      p1_merge_in = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = addr_ff[AW-1:0];
      wr_en       = 1'b0;
      wr_data     = (p1_merge_ff ? rd_data : 8'h00) | p1_data_ff;
      res_valid   = 1'b0;
      need_old    = addr_ff < written_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mode_in  = item.mode;
               n_in     = n_c;
               acc_in   = '0;
               k_in     = '0;
               state_in = ST_RUN;
               if (item.mode == MODE_WRITE) begin
                  bit_in   = wbit_ff;
                  addr_in  = wbyte_ff;
                  left_in  = BCW'(wcnt);
                  wdata_in = shifted;
                  und_in   = 1'b0;
                  ovf_in   = w_ovf;
                  wbyte_in = wend_sat[CW+2:3];
                  wbit_in  = wend_sat[2:0];
               end else begin
                  bit_in  = rbit_ff;
                  addr_in = rbyte_ff;
                  und_in  = r_und;
                  ovf_in  = 1'b0;
                  if (r_und) begin
                     left_in = '0;
                  end else begin
                     left_in  = (rcnt > ACC_BYTES) ? BCW'(ACC_BYTES) : BCW'(rcnt);
                     rbyte_in = rend[CW+2:3];
                     rbit_in  = rend[2:0];
                  end
               end
            end
         end
         ST_RUN: begin
            if (left_ff != '0) begin
               if (addr_ff < STORE_END) begin
                  // issue one byte; old contents are fetched only where needed
                  rd_en       = mode_ff | need_old;
                  p1_valid_in = 1'b1;
                  p1_addr_in  = addr_ff[AW-1:0];
                  p1_data_in  = wdata_ff[7:0];
                  p1_merge_in = (mode_ff == MODE_WRITE) && need_old;
                  wdata_in    = wdata_ff >> 8;
                  addr_in     = addr_ff + CW'(1);
                  left_in     = left_ff - BCW'(1);
               end else begin
                  // past the end of the store: drop the rest
                  left_in = '0;
               end
            end else begin
               res_valid = 1'b1;
               state_in  = res_ready ? ST_IDLE : ST_DONE;
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // second stage: write back the merged byte or gather the read byte
      if (p1_valid_ff) begin
         if (mode_ff == MODE_WRITE) begin
            wr_en = 1'b1;
            if (CW'(p1_addr_ff) >= written_ff) begin
               written_in = CW'(p1_addr_ff) + CW'(1);
            end
         end else begin
            for (int j = 0; j < ACC_BYTES; j++) begin
               if (k_ff == KW'(j)) begin
                  acc_in[j*8 +: 8] = rd_data;
               end
            end
            k_in = k_ff + KW'(1);
         end
      end
   end

   always_comb begin
      mask_r         = ~({VALUE_W{1'b1}} << n_ff);
      aligned        = acc_in >> bit_ff;
      res.read_value = aligned[VALUE_W-1:0] & mask_r;
      res.underrun   = und_ff;
      res.overflow   = ovf_ff;
   end

   assign idle = state_ff == ST_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         left_ff     <= '0;
         written_ff  <= '0;
         wbyte_ff    <= '0;
         wbit_ff     <= '0;
         rbyte_ff    <= '0;
         rbit_ff     <= '0;
         p1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         left_ff     <= left_in;
         written_ff  <= written_in;
         wbyte_ff    <= wbyte_in;
         wbit_ff     <= wbit_in;
         rbyte_ff    <= rbyte_in;
         rbit_ff     <= rbit_in;
         p1_valid_ff <= p1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      bit_ff      <= bit_in;
      n_ff        <= n_in;
      addr_ff     <= addr_in;
      wdata_ff    <= wdata_in;
      acc_ff      <= acc_in;
      k_ff        <= k_in;
      und_ff      <= und_in;
      ovf_ff      <= ovf_in;
      p1_addr_ff  <= p1_addr_in;
      p1_data_ff  <= p1_data_in;
      p1_merge_ff <= p1_merge_in;
   end

   bfsp_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (p1_addr_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/bit_field_stream_packer.sv =====
// Top level of the bit field stream packer: stream ports and result register.
`default_nettype none

// Packs fields of 1 to 32 bits, least significant bit first, into a byte store
// of STORE_BYTES bytes and reads them back in the same order. Each item on the
// req_ side is a write (req_tuser = 0) or a read (req_tuser = 1) and yields
// exactly one item on the rsp_ side. A write masks field_value to field_bits
// bits and ORs it in at the write position, appending zeroed bytes; bits that
// fall past the end of the store are dropped and overflow is flagged. A read
// takes field_bits bits at the read position; if any bit lies beyond the bytes
// written so far it returns zero, flags underrun and leaves the read position
// alone. A field_bits of zero counts as one, any above MAX_FIELD_BITS as
// MAX_FIELD_BITS. The result of an item is offered once the sequencer has
// issued every store byte its field touches (one to five; four or five for
// a 32-bit field, depending on the bit offset); a write that runs past the
// end of the store drops the rest. The byte store has one read and one write
// port and moves one byte per cycle, with reads and write-backs overlapped.
// An underrunning read touches no store bytes. A new item is taken once the
// previous one has left the sequencer, even while its result still waits in
// the output register. No clearing pass is needed after reset.
module bit_field_stream_packer #(
   parameter int STORE_BYTES    = 4096,
   parameter int MAX_FIELD_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] field_value, [37:32] field_bits, [39:38] zero
   input  logic [bfsp_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [0] mode
   input  logic [bfsp_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] read_value
   output logic [bfsp_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // [0] underrun, [1] overflow
   output logic [bfsp_pkg::RSP_TUSER_W-1:0]    rsp_tuser
);

   import bfsp_pkg::*;

   bfsp_item_type item;
   bfsp_res_type  res;
   bfsp_res_type  rsp_data_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          idle, start, res_valid, res_ready;

   // unpack the item
   assign item.mode        = req_tuser[0];
   assign item.field_value = req_tdata[VALUE_W-1:0];
   assign item.field_bits  = req_tdata[VALUE_W +: BITS_W];

   // take an item whenever the sequencer is free
   assign req_tready = idle;
   assign start      = req_tvalid & req_tready;

   // the result register accepts when empty or draining this cycle
   assign res_ready = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the payload until taken
   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff.read_value;
   assign rsp_tuser[0] = rsp_data_ff.underrun;
   assign rsp_tuser[1] = rsp_data_ff.overflow;

   bfsp_engine #(
      .STORE_BYTES    (STORE_BYTES),
      .MAX_FIELD_BITS (MAX_FIELD_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .item      (item),
      .idle      (idle),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/bfsp_checker.sv =====
// Port-level checker of the bit field stream packer and its bind.
`default_nettype none

module bfsp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [bfsp_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input logic [bfsp_pkg::REQ_TUSER_W-1:0]    req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [bfsp_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input logic [bfsp_pkg::RSP_TUSER_W-1:0]    rsp_tuser
);

   logic       in_acc, out_acc;
   logic [1:0] pend_ff, pend_in;

   assign in_acc  = req_tvalid & req_tready;
   assign out_acc = rsp_tvalid & rsp_tready;

   // items taken but not yet delivered
   always_comb begin
      pend_in = pend_ff;
      if (in_acc && !out_acc) begin
         pend_in = pend_ff + 2'd1;
      end else if (!in_acc && out_acc) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 2'd0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_underrun_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0 && !rsp_tuser[1])
      else $error("underrun result carries data or overflow");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      in_acc |=> !req_tready)
      else $error("item taken while the previous one is in flight");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      out_acc |-> pend_ff != 2'd0)
      else $error("result delivered without an item");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pend_ff == 2'd2 |-> !req_tready)
      else $error("more than two items outstanding");

endmodule

bind bit_field_stream_packer bfsp_checker u_bfsp_checker (.*);

`default_nettype wire

// ===== tb/bfsp_result_check.sv =====
// Result checker for the bit field stream packer: mirrors the byte store and compares every result.
module bfsp_result_check
   import bfsp_pkg::*;
#(
   parameter int STORE_BYTES    = 4096,
   parameter int MAX_FIELD_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   // [31:0] field_value, [37:32] field_bits, [39:38] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] mode
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [31:0] read_value
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   // [0] underrun, [1] overflow
   input  logic [RSP_TUSER_W-1:0] rsp_tuser,
   output int                     mismatch_count,
   output int                     results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned STORE_BITS = STORE_BYTES * 8;

   logic [7:0]   store_image [STORE_BYTES];
   int unsigned  bytes_filled;
   int unsigned  pack_pos;
   int unsigned  unpack_pos;
   bfsp_res_type field_results_due [$];

   // Apply one item to the mirrored store and return the result it must give.
   function automatic bfsp_res_type access_field(input logic mode,
                                                 input logic [VALUE_W-1:0] value,
                                                 input logic [BITS_W-1:0] bits_raw);
      bfsp_res_type res;
      int unsigned  width;
      int unsigned  p;
      int unsigned  stop;
      int           i;
      logic [63:0]  word;
      res   = '0;
      width = bits_raw;
      if (width == 0) width = 1;
      if (width > MAX_FIELD_BITS) width = MAX_FIELD_BITS;
      word = 64'(value);
      if (mode == MODE_WRITE) begin
         if (width < 64) word &= (64'd1 << width) - 64'd1;
         for (i = 0; i < width; i++) begin
            p = pack_pos + i;
            if (p >= STORE_BITS) begin
               res.overflow = 1'b1;
            end else begin
               while (bytes_filled <= p / 8) begin
                  store_image[bytes_filled] = 8'h00;
                  bytes_filled++;
               end
               if (word[i]) store_image[p / 8][p % 8] = 1'b1;
            end
         end
         stop     = pack_pos + width;
         pack_pos = (stop > STORE_BITS) ? STORE_BITS : stop;
      end else begin
         stop = unpack_pos + width;
         if (stop > bytes_filled * 8) begin
            // any bit past the filled bytes: zero, flag, hold the position
            res.underrun = 1'b1;
         end else begin
            word = '0;
            for (i = 0; i < width; i++) begin
               p       = unpack_pos + i;
               word[i] = store_image[p / 8][p % 8];
            end
            res.read_value = word[VALUE_W-1:0];
            unpack_pos     = stop;
         end
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                              input logic [VALUE_W-1:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      bfsp_res_type want;
      if (reset) begin
         bytes_filled   = 0;
         pack_pos       = 0;
         unpack_pos     = 0;
         mismatch_count = 0;
         field_results_due.delete();
      end else begin
         // retire the oldest result before taking a new item at the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (field_results_due.size() == 0) begin
               $display("%0t ns: unexpected item, expected none, actual %h/%b", $time,
                        rsp_tdata, rsp_tuser);
               mismatch_count++;
            end else begin
               want = field_results_due.pop_front();
               check_field("read_value", want.read_value, rsp_tdata);
               check_field("underrun", VALUE_W'(want.underrun), VALUE_W'(rsp_tuser[0]));
               check_field("overflow", VALUE_W'(want.overflow), VALUE_W'(rsp_tuser[1]));
            end
         end
         if (req_tvalid && req_tready)
            field_results_due.push_back(access_field(req_tuser[0], req_tdata[VALUE_W-1:0],
                                                     req_tdata[VALUE_W +: BITS_W]));
      end
      results_owed = field_results_due.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// Top of the bit field stream packer testbench: stimulus, stalls and the verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bfsp_pkg::*;

   localparam int STORE_BYTES    = 4096;
   localparam int MAX_FIELD_BITS = 32;
   // upper bound on the run length, above the slowest run; a longer run counts as hung
   localparam int CYCLE_LIMIT    = 300000;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // [31:0] field_value, [37:32] field_bits, [39:38] zero
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   // [0] mode
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [31:0] read_value
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // [0] underrun, [1] overflow
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   int          mismatch_count;
   int          results_owed;
   int          items_sent    = 0;
   int          results_seen  = 0;
   int          cycle_count   = 0;
   int unsigned bits_packed   = 0;
   bit          steady_flow   = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bit_field_stream_packer #(
      .STORE_BYTES   (STORE_BYTES),
      .MAX_FIELD_BITS(MAX_FIELD_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   bfsp_result_check #(
      .STORE_BYTES   (STORE_BYTES),
      .MAX_FIELD_BITS(MAX_FIELD_BITS)
   ) result_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .mismatch_count(mismatch_count),
      .results_owed  (results_owed)
   );

   // Stall the result side about a third of the time, never during steady flow.
   always @(posedge clock)
      rsp_tready <= steady_flow || ($urandom_range(0, 99) >= 33);

   // Count handshakes on both sides so the sender can wait for the block to drain.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) items_sent <= items_sent + 1;
         if (rsp_tvalid && rsp_tready) results_seen <= results_seen + 1;
      end
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Offer one item, idling at random beforehand, and hold it until taken.
   task automatic send_item(input logic mode, input logic [VALUE_W-1:0] value,
                            input logic [BITS_W-1:0] bits);
      int unsigned width;
      width = (bits == 0) ? 1 : ((bits > MAX_FIELD_BITS) ? MAX_FIELD_BITS : bits);
      while (!steady_flow && $urandom_range(0, 99) < 33) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_TDATA_W'({$urandom, $urandom});
         req_tuser  <= REQ_TUSER_W'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {{(REQ_TDATA_W - VALUE_W - BITS_W){1'b0}}, bits, value};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (mode == MODE_WRITE) bits_packed += width;
   endtask

   // Random item; write_pct sets the write share, wide_pct the share of widths 32..63.
   task automatic send_random(input int unsigned write_pct, input int unsigned wide_pct);
      logic               mode;
      logic [VALUE_W-1:0] value;
      logic [BITS_W-1:0]  bits;
      mode = ($urandom_range(0, 99) < write_pct) ? MODE_WRITE : MODE_READ;
      case ($urandom_range(0, 7))
         0: value = '0;
         1: value = '1;
         default: value = $urandom;
      endcase
      if ($urandom_range(0, 99) < wide_pct) bits = BITS_W'($urandom_range(32, 63));
      else bits = BITS_W'($urandom_range(0, 31));
      send_item(mode, value, bits);
   endtask

   // Drop the request and hold off until every item sent has produced its result.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_seen != items_sent) @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reads on an empty store must underrun, width zero included.
      send_item(MODE_READ, 32'hFFFF_FFFF, 6'd1);
      send_item(MODE_READ, 32'h0000_0000, 6'd0);
      // Width zero writes one bit; the three fields after it start at bit offset one.
      send_item(MODE_WRITE, 32'hFFFF_FFFF, 6'd0);
      send_item(MODE_WRITE, 32'hFFFF_FFFF, 6'd32);
      // Excess widths clamp to the maximum field width.
      send_item(MODE_WRITE, 32'hA5A5_A5A5, 6'd63);
      send_item(MODE_WRITE, 32'h1234_5678, 6'd7);
      send_item(MODE_WRITE, 32'h0000_0000, 6'd32);
      send_item(MODE_WRITE, 32'hFFFF_FFFF, 6'd33);
      send_item(MODE_READ, 32'h0000_0000, 6'd1);
      send_item(MODE_READ, 32'hFFFF_FFFF, 6'd32);
      send_item(MODE_READ, 32'h0000_0000, 6'd40);
      send_item(MODE_READ, 32'h0000_0000, 6'd0);
      send_item(MODE_READ, 32'h0000_0000, 6'd32);
      send_item(MODE_READ, 32'h0000_0000, 6'd32);
      // One bit past the filled bytes: underrun, then the exact remainder.
      send_item(MODE_READ, 32'h0000_0000, 6'd7);
      send_item(MODE_READ, 32'h0000_0000, 6'd6);
      send_item(MODE_READ, 32'h0000_0000, 6'd1);
      // Read a byte that is still being filled, then finish filling it.
      send_item(MODE_WRITE, 32'hFFFF_FFF5, 6'd3);
      send_item(MODE_READ, 32'h0000_0000, 6'd8);
      send_item(MODE_WRITE, 32'h5555_555F, 6'd5);
      send_item(MODE_WRITE, 32'h8000_0001, 6'd31);

      // Mixed traffic with reads close behind the writes.
      repeat (30) send_random(55, 30);
      drain_results();

      // Fill the store to its end and past it; start with a long run of no stalls.
      steady_flow = 1'b1;
      while (bits_packed < STORE_BYTES * 8 + 256) begin
         if (steady_flow && bits_packed > STORE_BYTES * 3) steady_flow = 1'b0;
         send_random(95, 95);
      end
      drain_results();

      // Writes now all overflow; reads keep unpacking the filled store.
      repeat (30) send_random(40, 50);
      req_tvalid <= 1'b0;

      drain_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && results_owed == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== bit_field_stream_packer.f =====
hw/rtl/bfsp_pkg.sv
hw/rtl/bfsp_ram.sv
hw/rtl/bfsp_engine.sv
hw/rtl/bit_field_stream_packer.sv
hw/rtl/bfsp_checker.sv
tb/bfsp_result_check.sv
tb/tb_top.sv
